// File: rtl/core/nbdscsi_pkg.sv
package nbdscsi_pkg;

	// request header constants
	localparam logic [31:0] REQ_MAGIC = 32'h2560_9513;

	localparam logic [15:0] CMD_READ  = 16'd0;
	localparam logic [15:0] CMD_WRITE = 16'd1;
	localparam logic [15:0] CMD_DISC  = 16'd2;
	localparam logic [15:0] CMD_FLUSH = 16'd3;

	// result kinds
	localparam logic [2:0] KIND_READ  = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_SYNC  = 3'd2;
	localparam logic [2:0] KIND_REPLY = 3'd3;
	localparam logic [2:0] KIND_CLOSE = 3'd4;

	// reply status
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_INVAL = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_BLK_BYTES    = 2'd0;
	localparam logic [1:0] REG_TOTAL_BLOCKS = 2'd1;

	localparam logic [16:0] BLK_BYTES_RST = 17'd512;

	// most commands per request before the reply
	localparam int MAX_CMDS = 5;

	// default limits
	localparam int MAX_REQUEST_BYTES_DEF = 134217728;
	localparam int CHUNK_BLOCKS_DEF      = 65535;

endpackage

// File: rtl/core/nbdscsi_div.sv
module nbdscsi_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] offset,
	input  logic [31:0] length,
	input  logic [16:0] divisor,
	output logic        done,
	output logic [63:0] lba,
	output logic [31:0] nblk,
	output logic        off_rem_nz,
	output logic        len_rem_nz
);

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] oq_q;
	logic [31:0] lq_q;
	logic [16:0] orem_q;
	logic [16:0] lrem_q;
	logic [17:0] o_trial;
	logic [17:0] l_trial;
	logic [17:0] o_diff;
	logic [17:0] l_diff;
	logic        o_ge;
	logic        l_ge;

	// one quotient bit per cycle for each dividend
	assign o_trial = {orem_q, oq_q[63]};
	assign l_trial = {lrem_q, lq_q[31]};
	assign o_ge    = o_trial >= {1'b0, divisor};
	assign l_ge    = l_trial >= {1'b0, divisor};
	assign o_diff  = o_trial - {1'b0, divisor};
	assign l_diff  = l_trial - {1'b0, divisor};

	// control: 64 steps, length joins for the last 32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift registers holding remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			oq_q   <= offset;
			lq_q   <= length;
			orem_q <= '0;
			lrem_q <= '0;
		end else if (busy_q) begin
			orem_q <= o_ge ? o_diff[16:0] : o_trial[16:0];
			oq_q   <= {oq_q[62:0], o_ge};
			if (!cnt_q[5]) begin
				lrem_q <= l_ge ? l_diff[16:0] : l_trial[16:0];
				lq_q   <= {lq_q[30:0], l_ge};
			end
		end
	end

	assign done       = done_q;
	assign lba        = oq_q;
	assign nblk       = lq_q;
	assign off_rem_nz = orem_q != 17'd0;
	assign len_rem_nz = lrem_q != 17'd0;

endmodule

// File: rtl/core/nbd_request_to_scsi_translator_core.sv
// sequence: a close or single-reply request goes from accept to its result state, a flush
// to its sync and then its reply state; a read or write runs a bit-serial divide
// by the block length, waits in the divide state to see it done, passes the check state,
// then issues one command per cycle unless the output stalls, and the reply last
// a new request is taken only in idle, once the last reply or close is registered;
// arst_n opens the session, block length 512, total_blocks 0
module nbd_request_to_scsi_translator_core #(
	parameter int MAX_REQUEST_BYTES = nbdscsi_pkg::MAX_REQUEST_BYTES_DEF,
	parameter int CHUNK_BLOCKS      = nbdscsi_pkg::CHUNK_BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] request_magic,
	input  logic [15:0] command_type,
	input  logic [63:0] request_handle,
	input  logic [63:0] byte_offset,
	input  logic [31:0] byte_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  result_kind,
	output logic [31:0] logical_block,
	output logic [15:0] block_count,
	output logic        reply_status,
	output logic [63:0] reply_handle,
	output logic [31:0] payload_bytes,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam logic [31:0] MAX_BYTES = 32'(MAX_REQUEST_BYTES);
	localparam logic [15:0] CHUNK     = 16'(CHUNK_BLOCKS);
	localparam logic [31:0] MAX_RUN   = 32'(nbdscsi_pkg::MAX_CMDS * CHUNK_BLOCKS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_CHK   = 3'd2;
	localparam logic [2:0] ST_CMD   = 3'd3;
	localparam logic [2:0] ST_SYNC  = 3'd4;
	localparam logic [2:0] ST_REPLY = 3'd5;
	localparam logic [2:0] ST_CLOSE = 3'd6;

	logic [2:0]  state_q;
	logic        closed_q;
	logic [16:0] blk_bytes_q;
	logic [31:0] total_blocks_q;
	logic [63:0] handle_q;
	logic        is_write_q;
	logic        status_q;
	logic [31:0] drain_q;
	logic [31:0] lba_q;
	logic [31:0] left_q;

	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [31:0] lblk_q;
	logic [15:0] bcnt_q;
	logic        ostat_q;
	logic [63:0] ohandle_q;
	logic [31:0] pay_q;
	logic        last_q;

	logic        accept;
	logic        slot_free;
	logic        emit;
	logic        div_start;
	logic        div_done;
	logic [63:0] div_lba;
	logic [31:0] div_nblk;
	logic        off_rem_nz;
	logic        len_rem_nz;
	logic        pre_bad;
	logic        is_rw;
	logic [32:0] end_blk;
	logic        chk_bad;
	logic [15:0] chunk;
	logic [32:0] chunk_bytes;

	assign in_ready  = state_q == ST_IDLE;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = slot_free && (state_q == ST_CMD || state_q == ST_SYNC ||
	                   state_q == ST_REPLY || state_q == ST_CLOSE);

	// request classification at accept
	assign is_rw   = command_type == nbdscsi_pkg::CMD_READ ||
	                 command_type == nbdscsi_pkg::CMD_WRITE;
	assign pre_bad = blk_bytes_q == 17'd0 || byte_length == 32'd0 ||
	                 byte_length > MAX_BYTES;
	assign div_start = accept && !closed_q && request_magic == nbdscsi_pkg::REQ_MAGIC &&
	                   is_rw && !pre_bad;

	nbdscsi_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.offset     (byte_offset),
		.length     (byte_length),
		.divisor    (blk_bytes_q),
		.done       (div_done),
		.lba        (div_lba),
		.nblk       (div_nblk),
		.off_rem_nz (off_rem_nz),
		.len_rem_nz (len_rem_nz)
	);

	// bounds and run length check
	assign end_blk = {1'b0, div_lba[31:0]} + {1'b0, div_nblk};
	assign chk_bad = off_rem_nz || len_rem_nz || div_lba[63:32] != 32'd0 ||
	                 end_blk > {1'b0, total_blocks_q} || div_nblk > MAX_RUN;

	// next command size and its write bytes
	assign chunk       = left_q > {16'd0, CHUNK} ? CHUNK : left_q[15:0];
	assign chunk_bytes = chunk * blk_bytes_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_bytes_q    <= nbdscsi_pkg::BLK_BYTES_RST;
			total_blocks_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == nbdscsi_pkg::REG_BLK_BYTES)
				blk_bytes_q <= cfg_data[16:0];
			else if (cfg_index == nbdscsi_pkg::REG_TOTAL_BLOCKS)
				total_blocks_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			closed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !closed_q) begin
						if (request_magic != nbdscsi_pkg::REQ_MAGIC ||
						    command_type == nbdscsi_pkg::CMD_DISC) begin
							closed_q <= 1'b1;
							state_q  <= ST_CLOSE;
						end else if (command_type == nbdscsi_pkg::CMD_FLUSH)
							state_q <= ST_SYNC;
						else if (!is_rw || pre_bad)
							state_q <= ST_REPLY;
						else
							state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= chk_bad ? ST_REPLY : ST_CMD;
				end
				ST_CMD: begin
					if (slot_free && left_q == {16'd0, chunk})
						state_q <= ST_REPLY;
				end
				ST_SYNC: begin
					if (slot_free)
						state_q <= ST_REPLY;
				end
				ST_REPLY, ST_CLOSE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			// output valid: set on a new result, cleared once taken
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// request context and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			handle_q   <= request_handle;
			is_write_q <= command_type == nbdscsi_pkg::CMD_WRITE;
			status_q   <= (is_rw || command_type != nbdscsi_pkg::CMD_FLUSH) ?
			              nbdscsi_pkg::STATUS_INVAL : nbdscsi_pkg::STATUS_OK;
			drain_q    <= command_type == nbdscsi_pkg::CMD_WRITE ? byte_length : 32'd0;
		end
		if (state_q == ST_CHK) begin
			lba_q  <= div_lba[31:0];
			left_q <= div_nblk;
			if (!chk_bad) begin
				status_q <= nbdscsi_pkg::STATUS_OK;
				drain_q  <= '0;
			end
		end
		if (slot_free) begin
			unique case (state_q)
				ST_CMD: begin
					kind_q    <= is_write_q ? nbdscsi_pkg::KIND_WRITE : nbdscsi_pkg::KIND_READ;
					lblk_q    <= lba_q;
					bcnt_q    <= chunk;
					ostat_q   <= nbdscsi_pkg::STATUS_OK;
					ohandle_q <= '0;
					pay_q     <= is_write_q ? chunk_bytes[31:0] : 32'd0;
					last_q    <= 1'b0;
					lba_q     <= lba_q + {16'd0, chunk};
					left_q    <= left_q - {16'd0, chunk};
				end
				ST_SYNC: begin
					kind_q    <= nbdscsi_pkg::KIND_SYNC;
					lblk_q    <= '0;
					bcnt_q    <= '0;
					ostat_q   <= nbdscsi_pkg::STATUS_OK;
					ohandle_q <= '0;
					pay_q     <= '0;
					last_q    <= 1'b0;
				end
				ST_REPLY: begin
					kind_q    <= nbdscsi_pkg::KIND_REPLY;
					lblk_q    <= '0;
					bcnt_q    <= '0;
					ostat_q   <= status_q;
					ohandle_q <= handle_q;
					pay_q     <= drain_q;
					last_q    <= 1'b1;
				end
				ST_CLOSE: begin
					kind_q    <= nbdscsi_pkg::KIND_CLOSE;
					lblk_q    <= '0;
					bcnt_q    <= '0;
					ostat_q   <= nbdscsi_pkg::STATUS_OK;
					ohandle_q <= '0;
					pay_q     <= '0;
					last_q    <= 1'b1;
				end
				default: begin
					kind_q <= kind_q;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign logical_block = lblk_q;
	assign block_count   = bcnt_q;
	assign reply_status  = ostat_q;
	assign reply_handle  = ohandle_q;
	assign payload_bytes = pay_q;
	assign last_of_run   = last_q;

endmodule

// File: rtl/core/nbdscsi_chk.sv
module nbdscsi_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  result_kind,
	input logic        reply_status,
	input logic        last_of_run,
	input logic [63:0] reply_handle
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
		$stable(reply_handle))
		else $error("result changed while stalled");

	// kind within range
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_kind <= nbdscsi_pkg::KIND_CLOSE)
		else $error("result kind out of range");

	// reply and close end a request, commands never do
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_of_run == (result_kind == nbdscsi_pkg::KIND_REPLY ||
		result_kind == nbdscsi_pkg::KIND_CLOSE))
		else $error("last flag wrong for kind");

	// only a reply carries a status
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != nbdscsi_pkg::KIND_REPLY |-> !reply_status)
		else $error("status on a non-reply");

endmodule

bind nbd_request_to_scsi_translator_core nbdscsi_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_kind  (result_kind),
	.reply_status (reply_status),
	.last_of_run  (last_of_run),
	.reply_handle (reply_handle)
);

// File: bench/nbd_scsi_checker.sv
`timescale 1ns / 100ps

module nbd_scsi_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] request_magic,
	input  logic [15:0] command_type,
	input  logic [63:0] request_handle,
	input  logic [63:0] byte_offset,
	input  logic [31:0] byte_length,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  result_kind,
	input  logic [31:0] logical_block,
	input  logic [15:0] block_count,
	input  logic        reply_status,
	input  logic [63:0] reply_handle,
	input  logic [31:0] payload_bytes,
	input  logic        last_of_run,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] lba;
		logic [15:0] cnt;
		logic        status;
		logic [63:0] handle;
		logic [31:0] pay;
		logic        last;
	} scsi_result_t;

	scsi_result_t expected_q[$];
	logic [16:0] blk_size;
	logic [31:0] dev_blocks;
	logic        closed;

	assign pending = expected_q.size();

	function automatic scsi_result_t mk(logic [2:0] k, logic [31:0] l, logic [15:0] c,
			logic s, logic [63:0] h, logic [31:0] p, logic la);
		scsi_result_t r;
		r.kind = k; r.lba = l; r.cnt = c; r.status = s; r.handle = h; r.pay = p; r.last = la;
		return r;
	endfunction

	// translate one request header into its expected commands and reply
	task automatic translate_request(logic [31:0] mg, logic [15:0] ct, logic [63:0] hd,
			logic [63:0] off, logic [31:0] len);
		logic        wr;
		logic        ok;
		logic [63:0] lba;
		logic [63:0] nblk;
		logic [63:0] done;
		logic [63:0] c;
		logic [31:0] drain;
		if (closed)
			return;
		if (mg != nbdscsi_pkg::REQ_MAGIC || ct == nbdscsi_pkg::CMD_DISC) begin
			closed = 1'b1;
			expected_q.push_back(mk(nbdscsi_pkg::KIND_CLOSE, '0, '0, 1'b0, '0, '0, 1'b1));
			return;
		end
		if (ct == nbdscsi_pkg::CMD_FLUSH) begin
			expected_q.push_back(mk(nbdscsi_pkg::KIND_SYNC, '0, '0, 1'b0, '0, '0, 1'b0));
			expected_q.push_back(mk(nbdscsi_pkg::KIND_REPLY, '0, '0, nbdscsi_pkg::STATUS_OK,
				hd, '0, 1'b1));
			return;
		end
		if (ct != nbdscsi_pkg::CMD_READ && ct != nbdscsi_pkg::CMD_WRITE) begin
			expected_q.push_back(mk(nbdscsi_pkg::KIND_REPLY, '0, '0, nbdscsi_pkg::STATUS_INVAL,
				hd, '0, 1'b1));
			return;
		end
		wr = (ct == nbdscsi_pkg::CMD_WRITE);
		drain = wr ? len : 32'd0;
		ok = 1'b1;
		lba = '0;
		nblk = '0;
		if (blk_size == 0 || len == 0 || len > nbdscsi_pkg::MAX_REQUEST_BYTES_DEF)
			ok = 1'b0;
		else if (off % blk_size != 0 || len % blk_size != 0)
			ok = 1'b0;
		if (ok) begin
			lba = off / blk_size;
			nblk = len / blk_size;
			if (lba > dev_blocks || nblk > 64'(dev_blocks) - lba)
				ok = 1'b0;
		end
		if (ok && (nblk + nbdscsi_pkg::CHUNK_BLOCKS_DEF - 1) / nbdscsi_pkg::CHUNK_BLOCKS_DEF >
				nbdscsi_pkg::MAX_CMDS)
			ok = 1'b0;
		if (!ok) begin
			expected_q.push_back(mk(nbdscsi_pkg::KIND_REPLY, '0, '0, nbdscsi_pkg::STATUS_INVAL,
				hd, drain, 1'b1));
			return;
		end
		done = '0;
		while (done < nblk) begin
			c = nblk - done;
			if (c > nbdscsi_pkg::CHUNK_BLOCKS_DEF)
				c = 64'(nbdscsi_pkg::CHUNK_BLOCKS_DEF);
			expected_q.push_back(mk(wr ? nbdscsi_pkg::KIND_WRITE : nbdscsi_pkg::KIND_READ,
				32'(lba + done), 16'(c), 1'b0, '0, wr ? 32'(c * blk_size) : 32'd0, 1'b0));
			done += c;
		end
		expected_q.push_back(mk(nbdscsi_pkg::KIND_REPLY, '0, '0, nbdscsi_pkg::STATUS_OK, hd,
			'0, 1'b1));
	endtask

	// watch the channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		scsi_result_t got;
		scsi_result_t want;
		if (!arst_n) begin
			blk_size <= nbdscsi_pkg::BLK_BYTES_RST;
			dev_blocks <= '0;
			closed = 1'b0;
			expected_q.delete();
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == nbdscsi_pkg::REG_BLK_BYTES)
					blk_size <= cfg_data[16:0];
				else if (cfg_index == nbdscsi_pkg::REG_TOTAL_BLOCKS)
					dev_blocks <= cfg_data;
			end
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				got = mk(result_kind, logical_block, block_count, reply_status, reply_handle,
					payload_bytes, last_of_run);
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("mismatch: expected %h actual %h", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready)
				translate_request(request_magic, command_type, request_handle, byte_offset,
					byte_length);
		end
	end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] request_magic = '0;
	logic [15:0] command_type = '0;
	logic [63:0] request_handle = '0;
	logic [63:0] byte_offset = '0;
	logic [31:0] byte_length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  result_kind;
	logic [31:0] logical_block;
	logic [15:0] block_count;
	logic        reply_status;
	logic [63:0] reply_handle;
	logic [31:0] payload_bytes;
	logic        last_of_run;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          results_seen;
	int          requests_sent = 0;
	logic [31:0] cur_bs;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	nbd_request_to_scsi_translator_core uut (.*);

	nbd_scsi_checker chk (.*);

	// receiver stall pattern, with one long hold-off early in the random phases
	initial begin
		int mode;
		int hold;
		bit held;
		hold = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			mode = (requests_sent / 60) % 3;
			if (!held && requests_sent >= 40) begin
				held = 1'b1;
				hold = 2000;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				hold = hold - 1;
			end else if (mode == 0)
				out_ready <= 1'b1;
			else if (mode == 1)
				out_ready <= ($urandom_range(0, 3) != 0);
			else
				out_ready <= ($urandom_range(0, 3) == 0);
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering, wait until every expected result is in, then let the divider drain
	task automatic drain_block();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic set_geometry(logic [31:0] bs, logic [31:0] tot);
		drain_block();
		write_reg(nbdscsi_pkg::REG_BLK_BYTES, bs);
		write_reg(nbdscsi_pkg::REG_TOTAL_BLOCKS, tot);
		cur_bs = bs;
	endtask

	// offer one request and hold it until taken
	task automatic send_request(logic [31:0] mg, logic [15:0] ct, logic [63:0] hd,
			logic [63:0] off, logic [31:0] len);
		in_valid <= 1'b1;
		request_magic <= mg;
		command_type <= ct;
		request_handle <= hd;
		byte_offset <= off;
		byte_length <= len;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic gap();
		in_valid <= 1'b0;
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly well-formed random read/write requests with some noise
	task automatic random_request();
		int pick;
		logic [15:0] ct;
		logic [63:0] off;
		logic [31:0] len;
		logic [31:0] bs;
		bs = (cur_bs == 0) ? 512 : cur_bs;
		pick = $urandom_range(0, 99);
		ct = $urandom_range(0, 1) ? nbdscsi_pkg::CMD_WRITE : nbdscsi_pkg::CMD_READ;
		off = 64'(bs) * $urandom_range(0, 2000);
		len = bs * $urandom_range(1, 300);
		if (pick < 3)
			ct = nbdscsi_pkg::CMD_FLUSH;
		else if (pick < 6)
			ct = 16'($urandom_range(4, 65535));
		else if (pick < 10)
			len = $urandom;
		else if (pick < 14)
			off = rand64();
		else if (pick < 18)
			len = bs * $urandom_range(65535, 327675) / bs * bs;
		else if (pick < 20)
			len = 0;
		else if (pick < 22)
			off = off + $urandom_range(1, 511);
		send_request(nbdscsi_pkg::REQ_MAGIC, ct, rand64(), off, len);
	endtask

	initial begin
		int n;
		cur_bs = 512;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset geometry rejects everything
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, '1, '0, 512);
		set_geometry(512, 32'hFFFF_FFFF);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'h0, '0, 512);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_WRITE, '1, 64'h1FF_FFFF_FE00,
			32'd134217728);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_WRITE, 64'h5, '0,
			32'd134217729);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'h6, 64'd512, '0);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'h7, 64'd100, 512);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'h8, '0, 32'd600);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'h9, '1, 512);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_WRITE, 64'hA, 64'h1_FFFF_FFFE_00,
			1024);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_FLUSH, 64'hB, '0, '0);
		send_request(nbdscsi_pkg::REQ_MAGIC, 16'hFFFF, 64'hC, '0, 512);
		send_request(nbdscsi_pkg::REQ_MAGIC, 16'd4, 64'hD, '0, 512);
		set_geometry(32'h10000, 32'd10);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'hE, 64'h90000,
			32'h10000);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'hF, 64'h90000,
			32'h20000);
		set_geometry(0, 100);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_WRITE, 64'h10, '0, 512);
		set_geometry(512, 0);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'h11, '0, 512);

		// random phases over several geometries, long hold-off in the first
		for (int ph = 0; ph < 6; ph++) begin
			unique case (ph)
				0: set_geometry(512, 32'hFFFF_FFFF);
				1: set_geometry(4096, 32'd300000);
				2: set_geometry(32'h10000, 32'd5000);
				3: set_geometry(1024, 32'd2000);
				4: set_geometry(2048, $urandom);
				default: set_geometry(512, 32'd400);
			endcase
			n = 0;
			while (n < 60) begin
				repeat ($urandom_range(1, 8)) begin
					random_request();
					n++;
				end
				if ($urandom_range(0, 2) != 0)
					gap();
			end
		end

		// close paths: bad magic, then requests ignored by the closed session
		in_valid <= 1'b0;
		send_request(32'h0, nbdscsi_pkg::CMD_READ, 64'h12, '0, 512);
		send_request(nbdscsi_pkg::REQ_MAGIC, nbdscsi_pkg::CMD_READ, 64'h13, '0, 512);
		send_request($urandom, nbdscsi_pkg::CMD_DISC, 64'h14, '0, 512);
		in_valid <= 1'b0;

		drain_block();
		$display("requests sent: %0d, results checked: %0d, six geometries, close paths",
			requests_sent, results_seen);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
